[hdl/particle_contact_impulse_resolve_defines.svh]
// Assertion macros shared by the particle contact resolver RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef PARTICLE_CONTACT_IMPULSE_RESOLVE_DEFINES_SVH
`define PARTICLE_CONTACT_IMPULSE_RESOLVE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pcir_pkg.sv]
// Package for the particle contact resolver: widths, register indexes, stage record.
// No dependencies.
package pcir_pkg;

    localparam int IN_W   = 344;
    localparam int OUT_W  = 384;
    localparam int CFG_W  = 17;
    localparam int NSTAGE = 31;

    localparam logic [15:0] DT_RESET = 16'd1092;
    localparam logic [16:0] REST_ONE = 17'd65536;

    typedef enum logic [0:0] {
        REG_DELTA_TIME  = 1'b0,
        REG_RESTITUTION = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][31:0]       v;
        logic [2:0][31:0]       a;
        logic [2:0][17:0]       n;
        logic [31:0]            ima;
        logic [31:0]            imb;
        logic [31:0]            pen;
        logic [2:0][49:0]       pv;
        logic [2:0][49:0]       pa;
        logic [34:0]            sep;
        logic [34:0]            accdot;
        logic [34:0]            accsep;
        logic [35:0]            nsep1;
        logic [35:0]            term2;
        logic                   acc_neg;
        logic [35:0]            dv;
        logic [32:0]            total;
        logic [33:0]            rem_a;
        logic [33:0]            rem_b;
        logic [24:0]            qa;
        logic [24:0]            qb;
        logic                   tot_zero;
        logic [30:0]            penv;
        logic [42:0]            dva_lo;
        logic [42:0]            dva_hi;
        logic [42:0]            dvb_lo;
        logic [42:0]            dvb_hi;
        logic [55:0]            pma;
        logic [55:0]            pmb;
        logic [3:0][35:0]       mag;
        logic [3:0][2:0][36:0]  nl;
        logic [3:0][2:0][36:0]  nh;
        logic [11:0][31:0]      res;
    } stage_t;

endpackage

[hdl/particle_contact_impulse_resolve.sv]
// Throughput: one contact per cycle while the output is not stalled; the 25-step
// restoring divider for the mass shares sets the pipeline depth, each stage
// holding one quotient bit of each share.
// A stalled stage holds its item while empty stages upstream of it keep filling.
// Reset (rst_n low, asynchronous) empties the pipeline and loads delta_time 1092
// and restitution 0.
`include "particle_contact_impulse_resolve_defines.svh"

module particle_contact_impulse_resolve
    import pcir_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // rel_vel_x, rel_vel_y, rel_vel_z, rel_acc_x, rel_acc_y, rel_acc_z,
    // normal_x, normal_y, normal_z, inv_mass_a, inv_mass_b, penetration, 2 zero bits
    input  logic [IN_W-1:0]     s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // dv_a_x, dv_a_y, dv_a_z, dv_b_x, dv_b_y, dv_b_z,
    // move_a_x, move_a_y, move_a_z, move_b_x, move_b_y, move_b_z
    output logic [OUT_W-1:0]    m_tdata
);

    localparam int ST_OUT = NSTAGE - 1;

    logic [15:0]        dt_reg;
    logic [16:0]        rest_reg;
    logic [NSTAGE-1:0]  vld_reg;
    logic [NSTAGE-1:0]  ld;
    stage_t             st_reg [NSTAGE];
    stage_t             st_next [NSTAGE];

    function automatic logic [31:0] sat32(input logic signed [55:0] x);
        if (x > 56'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (x < -56'sd2147483648)
            return 32'h8000_0000;
        else
            return x[31:0];
    endfunction

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg   <= DT_RESET;
            rest_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_DELTA_TIME:  dt_reg   <= cfg_wdata[15:0];
                REG_RESTITUTION: rest_reg <= (cfg_wdata > REST_ONE) ? REST_ONE : cfg_wdata;
                default:         dt_reg   <= dt_reg;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on.
    always_comb
    begin
        ld[ST_OUT] = !vld_reg[ST_OUT] || m_tready;
        for (int k = ST_OUT - 1; k >= 0; k--)
            ld[k] = !vld_reg[k] || ld[k + 1];
    end

    assign s_tready = ld[0];
    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = st_reg[ST_OUT].res;

    always_comb
    begin
        logic signed [51:0] sv;
        logic signed [51:0] sa;
        logic signed [51:0] accp;
        logic signed [35:0] negsep;
        logic signed [53:0] rp;
        logic signed [52:0] tp;
        logic signed [36:0] nsum;
        logic signed [36:0] nsel;
        logic signed [36:0] dvs;
        logic [33:0]        r2;
        logic [60:0]        mfull;
        logic signed [55:0] p;
        logic signed [55:0] q;

        st_next[0]     = st_reg[0];
        st_next[0].v   = s_tdata[95:0];
        st_next[0].a   = s_tdata[191:96];
        st_next[0].n   = s_tdata[245:192];
        st_next[0].ima = s_tdata[277:246];
        st_next[0].imb = s_tdata[309:278];
        st_next[0].pen = s_tdata[341:310];
        for (int k = 1; k < NSTAGE; k++)
            st_next[k] = st_reg[k - 1];

        // Stage 1: dot product terms, total inverse mass, positive part of the penetration.
        for (int c = 0; c < 3; c++)
        begin
            st_next[1].pv[c] = $signed(st_reg[0].v[c]) * $signed(st_reg[0].n[c]);
            st_next[1].pa[c] = $signed(st_reg[0].a[c]) * $signed(st_reg[0].n[c]);
        end
        st_next[1].total    = {1'b0, st_reg[0].ima} + {1'b0, st_reg[0].imb};
        st_next[1].tot_zero = (st_reg[0].ima == '0) && (st_reg[0].imb == '0);
        st_next[1].penv     = ($signed(st_reg[0].pen) > 32'sd0) ? st_reg[0].pen[30:0] : '0;

        // Stage 2: dot sums, top quotient bit of each share.
        sv = 52'($signed(st_reg[1].pv[0])) + 52'($signed(st_reg[1].pv[1]))
           + 52'($signed(st_reg[1].pv[2]));
        sa = 52'($signed(st_reg[1].pa[0])) + 52'($signed(st_reg[1].pa[1]))
           + 52'($signed(st_reg[1].pa[2]));
        st_next[2].sep    = sv[50:16];
        st_next[2].accdot = sa[50:16];
        st_next[2].qa     = '0;
        st_next[2].qb     = '0;
        st_next[2].qa[24] = {1'b0, st_reg[1].ima} >= st_reg[1].total;
        st_next[2].qb[24] = {1'b0, st_reg[1].imb} >= st_reg[1].total;
        st_next[2].rem_a  = st_next[2].qa[24] ?
                            34'({1'b0, st_reg[1].ima} - st_reg[1].total) : {2'b0, st_reg[1].ima};
        st_next[2].rem_b  = st_next[2].qb[24] ?
                            34'({1'b0, st_reg[1].imb} - st_reg[1].total) : {2'b0, st_reg[1].imb};

        // Stage 3: closing velocity over the frame, restitution of the separating speed.
        accp   = $signed(st_reg[2].accdot) * $signed({1'b0, dt_reg});
        negsep = -$signed({st_reg[2].sep[34], st_reg[2].sep});
        rp     = negsep * $signed({1'b0, rest_reg});
        st_next[3].accsep = accp[50:16];
        st_next[3].nsep1  = rp[51:16];

        // Stage 4: microcollision term.
        tp = $signed({1'b0, rest_reg}) * $signed(st_reg[3].accsep);
        st_next[4].term2   = tp[51:16];
        st_next[4].acc_neg = st_reg[3].accsep[34];

        // Stage 5: new separating velocity, clamped at 0 if accsep < 0; velocity change.
        nsum = 37'($signed(st_reg[4].nsep1)) + 37'($signed(st_reg[4].term2));
        if (st_reg[4].acc_neg)
            nsel = (nsum < 37'sd0) ? 37'sd0 : nsum;
        else
            nsel = 37'($signed(st_reg[4].nsep1));
        dvs = nsel - 37'($signed(st_reg[4].sep));
        if (!st_reg[4].sep[34] && (st_reg[4].sep != '0))
            st_next[5].dv = '0;
        else
            st_next[5].dv = dvs[35:0];

        // Stages 3 to 26: one restoring division step per stage for each share.
        for (int k = 3; k <= 26; k++)
        begin
            r2 = {st_reg[k - 1].rem_a[32:0], 1'b0};
            if (r2 >= {1'b0, st_reg[k - 1].total})
            begin
                st_next[k].qa[26 - k] = 1'b1;
                st_next[k].rem_a      = r2 - {1'b0, st_reg[k - 1].total};
            end
            else
                st_next[k].rem_a = r2;
            r2 = {st_reg[k - 1].rem_b[32:0], 1'b0};
            if (r2 >= {1'b0, st_reg[k - 1].total})
            begin
                st_next[k].qb[26 - k] = 1'b1;
                st_next[k].rem_b      = r2 - {1'b0, st_reg[k - 1].total};
            end
            else
                st_next[k].rem_b = r2;
        end

        // Stage 27: partial products of the changes with the shares.
        st_next[27].dva_lo = st_reg[26].dv[17:0] * st_reg[26].qa;
        st_next[27].dva_hi = st_reg[26].dv[35:18] * st_reg[26].qa;
        st_next[27].dvb_lo = st_reg[26].dv[17:0] * st_reg[26].qb;
        st_next[27].dvb_hi = st_reg[26].dv[35:18] * st_reg[26].qb;
        st_next[27].pma    = st_reg[26].penv * st_reg[26].qa;
        st_next[27].pmb    = st_reg[26].penv * st_reg[26].qb;

        // Stage 28: per-particle magnitudes.
        mfull = {st_reg[27].dva_hi, 18'b0} + 61'(st_reg[27].dva_lo);
        st_next[28].mag[0] = mfull[59:24];
        mfull = {st_reg[27].dvb_hi, 18'b0} + 61'(st_reg[27].dvb_lo);
        st_next[28].mag[1] = mfull[59:24];
        st_next[28].mag[2] = {4'b0, st_reg[27].pma[55:24]};
        st_next[28].mag[3] = {4'b0, st_reg[27].pmb[55:24]};

        // Stage 29: spread along the normal, split in two partial products.
        for (int m = 0; m < 4; m++)
            for (int c = 0; c < 3; c++)
            begin
                st_next[29].nl[m][c] = $signed(st_reg[28].n[c])
                                     * $signed({1'b0, st_reg[28].mag[m][17:0]});
                st_next[29].nh[m][c] = $signed(st_reg[28].n[c])
                                     * $signed({1'b0, st_reg[28].mag[m][35:18]});
            end

        // Stage 30: combine, second particle along the negative normal, saturate.
        for (int m = 0; m < 4; m++)
            for (int c = 0; c < 3; c++)
            begin
                p = (56'($signed(st_reg[29].nh[m][c])) <<< 18)
                  + 56'($signed(st_reg[29].nl[m][c]));
                if (m[0])
                    p = -p;
                q = p >>> 16;
                st_next[30].res[m * 3 + c] = st_reg[29].tot_zero ? 32'd0 : sat32(q);
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (ld[0])
                vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NSTAGE; k++)
                if (ld[k])
                    vld_reg[k] <= vld_reg[k - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTAGE; k++)
            if (ld[k])
                st_reg[k] <= st_next[k];
    end

    `PCIR_ASSERT_NOW(a_stall_from_output, !s_tready, m_tvalid && !m_tready,
        "input stalled while the output side is not blocked")
    `PCIR_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0],
        "accepted transaction did not enter the pipeline")
    `PCIR_ASSERT_NOW(a_immovable_zero, m_tvalid && st_reg[ST_OUT].tot_zero, m_tdata == '0,
        "immovable pair produced a nonzero result")
    `PCIR_ASSERT_NOW(a_rest_range, 1'b1, rest_reg <= REST_ONE,
        "restitution register above one")

endmodule
